// ===== hw/rtl/signed_divide_remainder_unit_assert.svh =====
// Assertion macros for the signed divide / remainder unit.
`ifndef SIGNED_DIVIDE_REMAINDER_UNIT_ASSERT_SVH
`define SIGNED_DIVIDE_REMAINDER_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SDR_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SDR_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hw/rtl/sdr_pkg.sv =====
// Package: widths, mode codes and shared types of the divide unit.
`timescale 1ns / 1ps
package sdr_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned ModeW = 2;
  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [ModeW-1:0] MODE_QUO32 = 2'd0;
  localparam logic [ModeW-1:0] MODE_REM32 = 2'd1;
  localparam logic [ModeW-1:0] MODE_QUO64 = 2'd2;
  localparam logic [ModeW-1:0] MODE_REM64 = 2'd3;

  // Classified operation, front end to back end.
  typedef struct packed {
    logic             wide;
    logic             want_rem;
    logic             zero;
    logic             neg_a;
    logic             neg_b;
    logic [DataW-1:0] mag_a;
    logic [DataW-1:0] mag_b;
  } sdr_op_t;

  // Per-stage control in the divide pipe.
  typedef struct packed {
    logic wide;
    logic want_rem;
    logic zero;
    logic neg_q;
    logic neg_r;
  } sdr_ctl_t;
endpackage

// ===== hw/rtl/sdr_if.sv =====
// Valid/ready channel interfaces for the divide unit.
`timescale 1ns / 1ps
interface sdr_in_if import sdr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ModeW-1:0]        mode;
  logic signed [DataW-1:0] dividend;
  logic signed [DataW-1:0] divisor;
  modport source (output valid, mode, dividend, divisor, input ready);
  modport sink (input valid, mode, dividend, divisor, output ready);
endinterface

interface sdr_out_if import sdr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] value;
  logic                    divide_by_zero;
  modport source (output valid, value, divide_by_zero, input ready);
  modport sink (input valid, value, divide_by_zero, output ready);
endinterface

// ===== hw/rtl/signed_divide_remainder_unit.sv =====
// Top level: signed 32/64-bit truncating divide and remainder unit.
`timescale 1ns / 1ps
// Channel | Dir | Fields
// in_     | in  | mode[1:0], dividend[63:0], divisor[63:0]
// out_    | out | value[63:0], divide_by_zero
//
// One transaction per cycle sustained while the output is not stalled; an
// accepted transaction is written into the queue, enters stage 0 from there,
// then passes 64 restoring divide stages (one quotient bit each) and one output register.
// rst_n is synchronous and clears all valid and queue state.
// Output stall freezes the whole divide pipe; the front queue keeps
// accepting until it is full.
module signed_divide_remainder_unit import sdr_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input logic       clk,
  input logic       rst_n,
  sdr_in_if.sink    in_ch,
  sdr_out_if.source out_ch
);
  logic    op_valid, op_ready;
  sdr_op_t op;

  // Classify and queue.
  sdr_front #(.Depth(FifoDepth)) u_front (
    .clk, .rst_n, .in_ch, .op_valid, .op_ready, .op
  );

  // Pipelined divide and sign correction.
  sdr_back u_back (
    .clk, .rst_n, .op_valid, .op_ready, .op, .out_ch
  );
endmodule

// ===== hw/rtl/sdr_front.sv =====
// Front end: operand selection, zero check, magnitudes, into a small queue.
`timescale 1ns / 1ps
module sdr_front import sdr_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  sdr_in_if.sink   in_ch,
  output logic     op_valid,
  input  logic     op_ready,
  output sdr_op_t  op
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  sdr_op_t           q_r [Depth];
  logic [AW-1:0]     wp_r, rp_r;
  logic [AW:0]       cnt_r;
  logic              push, pop;
  logic [DataW-1:0]  a, b;
  logic              wide;
  sdr_op_t           cls;

  always_comb begin
    wide = in_ch.mode[1];
    a = wide ? in_ch.dividend : {{32{in_ch.dividend[31]}}, in_ch.dividend[31:0]};
    b = wide ? in_ch.divisor : {{32{in_ch.divisor[31]}}, in_ch.divisor[31:0]};
    cls.wide     = wide;
    cls.want_rem = in_ch.mode[0];
    cls.zero     = (b == '0);
    cls.neg_a    = a[DataW-1];
    cls.neg_b    = b[DataW-1];
    cls.mag_a    = a[DataW-1] ? (~a + 1'b1) : a;
    cls.mag_b    = b[DataW-1] ? (~b + 1'b1) : b;
  end

  assign in_ch.ready = (cnt_r != (AW+1)'(Depth));
  assign push = in_ch.valid && in_ch.ready;
  assign op_valid = (cnt_r != '0);
  assign pop = op_valid && op_ready;
  assign op = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ===== hw/rtl/sdr_back.sv =====
// Back end: 64-stage restoring divide pipeline plus sign fix and output register.
`timescale 1ns / 1ps
module sdr_back import sdr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     op_valid,
  output logic     op_ready,
  input  sdr_op_t  op,
  sdr_out_if.source out_ch
);
  `include "signed_divide_remainder_unit_assert.svh"

  localparam int unsigned N = DataW;

  // Stage i holds state after i+1 quotient bits.
  logic             v_r   [N];
  sdr_ctl_t         c_r   [N];
  logic [N-1:0]     rem_r [N];
  logic [N-1:0]     quo_r [N];  // remaining dividend bits shift into quotient
  logic [N-1:0]     den_r [N];
  logic             adv;

  logic             o_v_r;
  logic [N-1:0]     o_val_r;
  logic             o_dz_r;

  // Whole pipe moves together; stalls only when output is full and not taken.
  assign adv = !o_v_r || out_ch.ready;
  assign op_ready = adv;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_stage
      logic [N-1:0] rin, qin, din;
      logic         vin;
      sdr_ctl_t     cin;
      logic [N:0]   trial;
      logic [N:0]   diff;
      if (g == 0) begin : g_first
        assign rin = '0;
        assign qin = op.mag_a;
        assign din = op.mag_b;
        assign vin = op_valid;
        assign cin = '{wide: op.wide, want_rem: op.want_rem, zero: op.zero,
                       neg_q: op.neg_a ^ op.neg_b, neg_r: op.neg_a};
      end else begin : g_next
        assign rin = rem_r[g-1];
        assign qin = quo_r[g-1];
        assign din = den_r[g-1];
        assign vin = v_r[g-1];
        assign cin = c_r[g-1];
      end
      assign trial = {rin, qin[N-1]};
      assign diff = trial - {1'b0, din};
      always_ff @(posedge clk) begin
        if (adv) begin
          c_r[g]   <= cin;
          den_r[g] <= din;
          if (!diff[N]) begin
            rem_r[g] <= diff[N-1:0];
            quo_r[g] <= {qin[N-2:0], 1'b1};
          end else begin
            rem_r[g] <= trial[N-1:0];
            quo_r[g] <= {qin[N-2:0], 1'b0};
          end
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) v_r[g] <= 1'b0;
        else if (adv) v_r[g] <= vin;
      end
    end
  endgenerate

  sdr_ctl_t     fc;
  logic [N-1:0] mag, sv, res;
  always_comb begin
    fc  = c_r[N-1];
    mag = fc.want_rem ? rem_r[N-1] : quo_r[N-1];
    sv  = (fc.want_rem ? fc.neg_r : fc.neg_q) ? (~mag + 1'b1) : mag;
    if (fc.zero) res = '0;
    else if (fc.wide) res = sv;
    else res = {{32{sv[31]}}, sv[31:0]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_val_r <= res;
      o_dz_r  <= fc.zero;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else if (adv) o_v_r <= v_r[N-1];
  end

  assign out_ch.valid = o_v_r;
  assign out_ch.value = o_val_r;
  assign out_ch.divide_by_zero = o_dz_r;

  `SDR_ASSERT_IMP(a_dz_zero, clk, rst_n, o_v_r && o_dz_r, o_val_r == '0,
    "divide by zero result not zero")
  `SDR_ASSERT_NXT(a_hold, clk, rst_n, o_v_r && !out_ch.ready,
    o_v_r && $stable(o_val_r), "output changed while stalled")
  `SDR_ASSERT_IMP(a_ready, clk, rst_n, !o_v_r, op_ready,
    "pipe stalled with empty output")
endmodule

// ===== verif/signed_divide_remainder_unit_test.sv =====
// Testbench for the signed divide / remainder unit: directed and random checks.
`timescale 1ns / 1ps
module signed_divide_remainder_unit_test;
  import sdr_pkg::*;

  localparam int unsigned Latency = 70;

  typedef struct {
    logic [DataW-1:0] value;
    logic             dz;
  } div_result_t;

  logic clk;
  logic rst_n;

  sdr_in_if  in_ch ();
  sdr_out_if out_ch ();

  signed_divide_remainder_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  div_result_t quotient_queue[$];
  int unsigned mismatches;
  int unsigned hold_off_cycles;  // when nonzero the receiver stalls this long
  int unsigned hold_request;     // stall length asked for by a test
  bit          random_stall;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Predicted result of one division. Works on magnitudes in 64 bits; in
  // 32-bit modes operands are sign-extended first and the result after.
  function automatic div_result_t predict_division(logic [ModeW-1:0] mode,
                                                   logic [DataW-1:0] a_in,
                                                   logic [DataW-1:0] b_in);
    div_result_t      r;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] ma;
    logic [DataW-1:0] mb;
    logic [DataW-1:0] q;
    logic [DataW-1:0] rm;
    logic [DataW-1:0] v;
    bit               wide;
    bit               want_rem;
    wide = mode[1];
    want_rem = mode[0];
    a = wide ? a_in : {{32{a_in[31]}}, a_in[31:0]};
    b = wide ? b_in : {{32{b_in[31]}}, b_in[31:0]};
    if (b == '0) begin
      r.value = '0;
      r.dz = 1'b1;
      return r;
    end
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    rm = ma % mb;
    if (want_rem) v = a[63] ? -rm : rm;
    else v = (a[63] != b[63]) ? -q : q;
    if (!wide) v = {{32{v[31]}}, v[31:0]};
    r.value = v;
    r.dz = 1'b0;
    return r;
  endfunction

  function automatic int unsigned gap_length();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  // Send one transaction and queue its prediction on acceptance. valid
  // stays high after acceptance so a following item can go back to back.
  task automatic send_division(logic [ModeW-1:0] mode, logic [DataW-1:0] a,
                               logic [DataW-1:0] b, bit allow_gap = 1'b1);
    int unsigned gap;
    gap = allow_gap ? gap_length() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.dividend <= a;
    in_ch.divisor  <= b;
    do @(posedge clk); while (!in_ch.ready);
    quotient_queue.push_back(predict_division(mode, a, b));
  endtask

  // Result side: random short stalls, occasional long ones, and forced
  // hold-off stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_request != 0) begin
      hold_off_cycles <= hold_request - 1;
      hold_request = 0;
      out_ch.ready <= 1'b0;
    end else if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (random_stall) begin
      if ($urandom_range(199) == 0) begin
        hold_off_cycles <= $urandom_range(40, 4);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) < 10) ? 1'b0 : 1'b1;
      end
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    div_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (quotient_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result value=%h dz=%b", out_ch.value, out_ch.divide_by_zero);
      end else begin
        exp_r = quotient_queue.pop_front();
        if (out_ch.value !== exp_r.value || out_ch.divide_by_zero !== exp_r.dz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value=%h dz=%b, got value=%h dz=%b",
                     exp_r.value, exp_r.dz, out_ch.value, out_ch.divide_by_zero);
        end
      end
    end
  end

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (quotient_queue.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DataW-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Operand with interesting structure: extremes, small values, full random.
  function automatic logic [DataW-1:0] pick_operand(bit wide);
    logic [DataW-1:0] x;
    int unsigned      p;
    p = $urandom_range(99);
    x = rand64();
    if (p < 8) x = wide ? 64'h8000_0000_0000_0000 : {x[63:32], 32'h8000_0000};
    else if (p < 14) x = wide ? '1 : {x[63:32], 32'hFFFF_FFFF};
    else if (p < 18) x = wide ? '0 : {x[63:32], 32'h0};
    else if (p < 40) x = {{56{x[63]}}, x[7:0]};
    else if (p < 55) x = x >> $urandom_range(60);
    return x;
  endfunction

  task automatic test_directed();
    logic [DataW-1:0] min64;
    logic [DataW-1:0] max64;
    min64 = 64'h8000_0000_0000_0000;
    max64 = 64'h7FFF_FFFF_FFFF_FFFF;
    // Every mode with both signs to check truncation toward zero.
    send_division(MODE_QUO32, 64'd7, -64'sd2);
    send_division(MODE_REM32, -64'sd7, 64'd2);
    send_division(MODE_QUO64, -64'sd7, -64'sd2);
    send_division(MODE_REM64, 64'd7, -64'sd2);
    // Most negative by minus one wraps; remainder is zero.
    send_division(MODE_QUO64, min64, '1);
    send_division(MODE_REM64, min64, '1);
    send_division(MODE_QUO32, 64'h0000_0000_8000_0000, '1);
    send_division(MODE_REM32, 64'h1234_5678_8000_0000, 64'hABCD_0000_FFFF_FFFF);
    // Zero divisor, including garbage in the ignored high half.
    send_division(MODE_QUO64, max64, '0);
    send_division(MODE_REM64, min64, '0);
    send_division(MODE_QUO32, 64'd5, 64'hFFFF_FFFF_0000_0000);
    send_division(MODE_REM32, 64'd5, 64'h8000_0000_0000_0000);
    // A 64-bit divisor that is zero only in its low half is not zero.
    send_division(MODE_QUO64, max64, 64'h0000_0001_0000_0000);
    // Extremes of both operands.
    send_division(MODE_QUO64, max64, min64);
    send_division(MODE_REM64, min64, max64);
    send_division(MODE_QUO64, min64, 64'd1);
    send_division(MODE_REM64, max64, 64'd3);
    send_division(MODE_QUO32, 64'hFFFF_FFFF_7FFF_FFFF, 64'h0000_0000_8000_0000);
    send_division(MODE_REM32, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0001_0000_0007);
    send_division(MODE_QUO64, '0, max64);
    wait_drained();
  endtask

  task automatic test_random(int unsigned count);
    logic [ModeW-1:0] mode;
    for (int unsigned i = 0; i < count; i++) begin
      mode = $urandom_range(3);
      send_division(mode, pick_operand(mode[1]), pick_operand(mode[1]));
    end
  endtask

  // Receiver stalls long enough for the pipe and queue to fill while the
  // sender keeps offering back to back.
  task automatic test_backpressure();
    logic [ModeW-1:0] mode;
    hold_request = 200;
    for (int unsigned i = 0; i < 150; i++) begin
      mode = $urandom_range(3);
      send_division(mode, rand64(), rand64(), 1'b0);
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.dividend = '0;
    in_ch.divisor = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    hold_off_cycles = 0;
    hold_request = 0;
    random_stall = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    random_stall = 1'b1;
    test_random(900);
    wait_drained();  // sender pauses until everything is back
    test_backpressure();
    test_random(950);
    wait_drained();
    repeat (Latency) @(posedge clk);
    if (mismatches == 0 && quotient_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
